// ===== hw/rtl/c3sr_pkg.sv =====
// ----------------------------------------------------------------------------
// c3sr_pkg
// Shared constants, types and helpers of the 3x3 same-padding conv + ReLU.
// ----------------------------------------------------------------------------
package c3sr_pkg;

  localparam int MAX_SIZE   = 128;
  localparam int DATA_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int WGT_W      = 16;
  localparam int TAPS       = 3;
  localparam int PS_W       = 8;
  localparam int ADDR_W     = $clog2(MAX_SIZE);
  localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
  localparam int ENTRY_W    = 2 * DATA_W;
  localparam int KROW_W     = TAPS * WGT_W;
  localparam int PROD_W     = DATA_W + WGT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;
  // power of two: the result FIFO pointers wrap on their own
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_SIZE = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // one column of the window: [0] top row, [1] middle, [2] bottom
  typedef logic [TAPS-1:0][DATA_W-1:0] col_t;

  // one convolution: px[ky][kx], kx 0 = left column
  typedef struct packed {
    logic [TAPS-1:0][TAPS-1:0][DATA_W-1:0] px;
    logic                                  run_end;
    logic                                  plane_end;
  } job_t;

  typedef struct packed {
    logic [DATA_W-1:0] feature;
    logic              run_end;
    logic              plane_end;
  } res_t;

  // plane side with zero read as one and large values clipped
  function automatic logic [SIZE_W-1:0] side_of(input logic [PS_W-1:0] ps);
    logic [SIZE_W-1:0] s;
    if (int'(ps) > MAX_SIZE) begin
      s = SIZE_W'(MAX_SIZE);
    end else if (ps == '0) begin
      s = SIZE_W'(1);
    end else begin
      s = SIZE_W'(ps);
    end
    return s;
  endfunction

  // floored product, kept modulo 2^DATA_W (only the low bits reach the output)
  function automatic logic [DATA_W-1:0] term_of(input logic [DATA_W-1:0] px,
                                                input logic [WGT_W-1:0]  wgt);
    logic signed [PROD_W-1:0] p;
    p = $signed(px) * $signed(wgt);
    return p[FRAC_BITS +: DATA_W];
  endfunction

endpackage

// ===== hw/rtl/c3sr_mac.sv =====
// ----------------------------------------------------------------------------
// c3sr_mac
// Three-stage multiply-accumulate: nine products, row sums, bias and ReLU.
// ----------------------------------------------------------------------------
module c3sr_mac (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    job_valid,
  input  c3sr_pkg::job_t                                          job,
  input  logic [c3sr_pkg::TAPS-1:0][c3sr_pkg::KROW_W-1:0]        kernel,
  input  logic [c3sr_pkg::DATA_W-1:0]                             bias,
  output logic                                                    res_valid,
  output c3sr_pkg::res_t                                          res
);

  logic                                                              p1_valid_r;
  logic [c3sr_pkg::TAPS-1:0][c3sr_pkg::TAPS-1:0][c3sr_pkg::DATA_W-1:0] term_nxt;
  logic [c3sr_pkg::TAPS-1:0][c3sr_pkg::TAPS-1:0][c3sr_pkg::DATA_W-1:0] term_r;
  logic                                                              p1_run_end_r;
  logic                                                              p1_plane_end_r;

  logic                                               p2_valid_r;
  logic [c3sr_pkg::TAPS-1:0][c3sr_pkg::DATA_W-1:0]    rsum_nxt;
  logic [c3sr_pkg::TAPS-1:0][c3sr_pkg::DATA_W-1:0]    rsum_r;
  logic                                               p2_run_end_r;
  logic                                               p2_plane_end_r;

  logic                                               p3_valid_r;
  logic [c3sr_pkg::DATA_W-1:0]                        total;
  c3sr_pkg::res_t                                     res_r;

  always_comb begin
    for (int ky = 0; ky < c3sr_pkg::TAPS; ky++) begin
      for (int kx = 0; kx < c3sr_pkg::TAPS; kx++) begin
        term_nxt[ky][kx] = c3sr_pkg::term_of(
          job.px[ky][kx], kernel[ky][kx*c3sr_pkg::WGT_W +: c3sr_pkg::WGT_W]);
      end
    end
  end

  always_comb begin
    for (int ky = 0; ky < c3sr_pkg::TAPS; ky++) begin
      rsum_nxt[ky] = term_r[ky][0] + term_r[ky][1] + term_r[ky][2];
    end
  end

  // the sum wraps to the data width; a set sign bit clips to zero
  assign total = bias + rsum_r[0] + rsum_r[1] + rsum_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= job_valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    term_r         <= term_nxt;
    p1_run_end_r   <= job.run_end;
    p1_plane_end_r <= job.plane_end;
    rsum_r         <= rsum_nxt;
    p2_run_end_r   <= p1_run_end_r;
    p2_plane_end_r <= p1_plane_end_r;
    res_r.feature  <= total[c3sr_pkg::DATA_W-1] ? '0 : total;
    res_r.run_end  <= p2_run_end_r;
    res_r.plane_end <= p2_plane_end_r;
  end

  assign res_valid = p3_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/c3sr_fifo.sv =====
// ----------------------------------------------------------------------------
// c3sr_fifo
// Result queue between the MAC pipeline and the output channel.
// ----------------------------------------------------------------------------
module c3sr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  c3sr_pkg::res_t  din,
  output logic            out_valid,
  input  logic            out_ready,
  output c3sr_pkg::res_t  dout
);

  c3sr_pkg::res_t                    store_r [c3sr_pkg::FIFO_DEPTH];
  logic [c3sr_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [c3sr_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [c3sr_pkg::CNT_W-1:0]        fill_r;
  logic                              pop;

  assign out_valid = (fill_r != '0);
  assign dout      = store_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + c3sr_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + c3sr_pkg::FIFO_PTR_W'(1);
      end
      fill_r <= fill_r + c3sr_pkg::CNT_W'(push) - c3sr_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/conv3x3_same_relu.sv =====
// ----------------------------------------------------------------------------
// conv3x3_same_relu
// 3x3 convolution with zero padding and ReLU over a raster-order pixel plane.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | input     | in_valid / in_ready | in_opcode, in_pixel
//  out_    | output    | out_valid/out_ready | out_feature, out_run_end, out_plane_end
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while the credit counter has room; a pixel that closes a row
//  (two results) holds the window stage for a second window, as the single MAC
//  pipeline takes one window a cycle. A result passes the row store read, window,
//  products, row sums and bias/ReLU registers, then waits in an 8-entry result
//  queue. Input ready depends only on internal state: a credit counter covers the
//  MAC pipeline and queue, so out_ready stalls reach the input via that counter.
//  Reset is synchronous; the row store needs no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_same_relu (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_opcode,
  input  logic signed [c3sr_pkg::DATA_W-1:0]     in_pixel,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [c3sr_pkg::DATA_W-1:0]     out_feature,
  output logic                                   out_run_end,
  output logic                                   out_plane_end,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [c3sr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [c3sr_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int DATA_W  = c3sr_pkg::DATA_W;
  localparam int ADDR_W  = c3sr_pkg::ADDR_W;
  localparam int SIZE_W  = c3sr_pkg::SIZE_W;
  localparam int ENTRY_W = c3sr_pkg::ENTRY_W;
  localparam int CNT_W   = c3sr_pkg::CNT_W;

  // configuration
  logic [c3sr_pkg::TAPS-1:0][c3sr_pkg::KROW_W-1:0] kernel_r;
  logic [DATA_W-1:0]                               bias_r;
  logic [c3sr_pkg::PS_W-1:0]                       plane_size_r;

  // position counters
  logic [SIZE_W-1:0] row_count_r;
  logic [ADDR_W-1:0] col_count_r;
  logic [ADDR_W-1:0] drain_count_r;

  logic [SIZE_W-1:0] side;
  logic [SIZE_W-1:0] side_m1;
  logic              in_accept;
  logic              is_drain_in;
  logic              row_lt_side;
  logic              col_last;
  logic              drain_last;
  logic              pix_ok;
  logic              drn_ok;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;

  // row store: per column {row y-2, row y-1}
  logic [ENTRY_W-1:0] row_mem [c3sr_pkg::MAX_SIZE];
  logic [ENTRY_W-1:0] q_a_r;
  logic [ENTRY_W-1:0] q_b_r;

  // window stage
  logic               s1_valid_r;
  logic               s1_ph_r;
  logic               s1_drain_r;
  logic [DATA_W-1:0]  s1_pix_r;
  logic               s1_rzero_r;
  logic               s1_czero_r;
  logic               s1_emit_a_r;
  logic               s1_emit_b_r;
  logic               s1_dzero_r;
  logic               s1_rok_r;
  logic               s1_plast_r;
  logic [ADDR_W-1:0]  s1_waddr_r;
  logic               fwd_a_r;
  logic               fwd_b_r;
  logic [ENTRY_W-1:0] fwd_da_r;
  logic [ENTRY_W-1:0] fwd_db_r;

  logic [ENTRY_W-1:0] dat_a;
  logic [ENTRY_W-1:0] dat_b;
  logic [ENTRY_W-1:0] old_entry;
  logic [ENTRY_W-1:0] wdata;
  c3sr_pkg::col_t     col_pix;
  c3sr_pkg::col_t     col_ctr;
  c3sr_pkg::col_t     col_rgt;
  c3sr_pkg::col_t     col_lft;
  c3sr_pkg::col_t     win0_r;
  c3sr_pkg::col_t     win1_r;
  c3sr_pkg::col_t     win0_nxt;
  c3sr_pkg::col_t     win1_nxt;
  c3sr_pkg::col_t     sel_l;
  c3sr_pkg::col_t     sel_c;
  c3sr_pkg::col_t     sel_r;

  logic               need_job;
  logic               credit_ok;
  logic               job_go;
  logic               step_ok;
  logic               s1_exit;
  logic               s1_wr;

  c3sr_pkg::job_t     job_nxt;
  c3sr_pkg::job_t     job_r;
  logic               job_valid_r;
  logic [CNT_W-1:0]   count_r;

  logic               res_valid;
  c3sr_pkg::res_t     res;
  c3sr_pkg::res_t     fifo_dout;
  logic               pop;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r     <= '0;
      bias_r       <= '0;
      plane_size_r <= c3sr_pkg::PS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        c3sr_pkg::REG_KERNEL_TOP: kernel_r[0] <= cfg_data;
        c3sr_pkg::REG_KERNEL_MID: kernel_r[1] <= cfg_data;
        c3sr_pkg::REG_KERNEL_BOT: kernel_r[2] <= cfg_data;
        c3sr_pkg::REG_BIAS:       bias_r <= cfg_data[DATA_W-1:0];
        c3sr_pkg::REG_PLANE_SIZE: begin
          // size changes only between planes
          if (row_count_r == '0 && col_count_r == '0 && drain_count_r == '0) begin
            plane_size_r <= cfg_data[c3sr_pkg::PS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- intake
  assign side    = c3sr_pkg::side_of(plane_size_r);
  assign side_m1 = side - SIZE_W'(1);

  always_comb begin
    is_drain_in = (in_opcode == c3sr_pkg::OP_DRAIN);
    row_lt_side = row_count_r < side;
    col_last    = SIZE_W'(col_count_r) == side_m1;
    drain_last  = SIZE_W'(drain_count_r) == side_m1;
    pix_ok      = !is_drain_in && row_lt_side && (SIZE_W'(col_count_r) < side);
    drn_ok      = is_drain_in && !row_lt_side && (SIZE_W'(drain_count_r) < side);
    rd_addr_a   = is_drain_in ? drain_count_r + ADDR_W'(1) : col_count_r;
    rd_addr_b   = drain_count_r;
  end

  assign in_ready  = !s1_valid_r || s1_exit;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= '0;
      col_count_r   <= '0;
      drain_count_r <= '0;
    end else if (in_accept) begin
      if (pix_ok) begin
        if (col_last) begin
          col_count_r <= '0;
          row_count_r <= row_count_r + SIZE_W'(1);
        end else begin
          col_count_r <= col_count_r + ADDR_W'(1);
        end
      end else if (drn_ok) begin
        if (drain_last) begin
          row_count_r   <= '0;
          col_count_r   <= '0;
          drain_count_r <= '0;
        end else begin
          drain_count_r <= drain_count_r + ADDR_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- row store
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      row_mem[s1_waddr_r] <= wdata;
    end
    if (in_accept) begin
      q_a_r <= row_mem[rd_addr_a];
      q_b_r <= row_mem[rd_addr_b];
    end
  end

  // ---------------------------------------------------------------- window stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_ph_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= pix_ok || drn_ok;
      end else if (s1_exit) begin
        s1_valid_r <= 1'b0;
      end
      if (step_ok && !s1_drain_r && !s1_ph_r && s1_emit_b_r) begin
        s1_ph_r <= 1'b1;
      end else if (s1_exit) begin
        s1_ph_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_drain_r  <= is_drain_in;
      s1_pix_r    <= in_pixel;
      s1_rzero_r  <= (row_count_r == '0);
      s1_czero_r  <= (col_count_r == '0);
      s1_emit_a_r <= (row_count_r != '0) && (col_count_r != '0);
      s1_emit_b_r <= (row_count_r != '0) && col_last;
      s1_dzero_r  <= (drain_count_r == '0);
      s1_rok_r    <= !drain_last;
      s1_plast_r  <= drain_last;
      s1_waddr_r  <= col_count_r;
      // the store write leaving this edge is not yet visible to the read
      fwd_a_r     <= s1_wr && (rd_addr_a == s1_waddr_r);
      fwd_b_r     <= s1_wr && (rd_addr_b == s1_waddr_r);
      fwd_da_r    <= wdata;
      fwd_db_r    <= wdata;
    end
  end

  always_comb begin
    dat_a     = fwd_a_r ? fwd_da_r : q_a_r;
    dat_b     = fwd_b_r ? fwd_db_r : q_b_r;
    old_entry = s1_rzero_r ? '0 : dat_a;
    wdata     = {old_entry[DATA_W-1:0], s1_pix_r};

    col_pix[0] = old_entry[ENTRY_W-1:DATA_W];
    col_pix[1] = old_entry[DATA_W-1:0];
    col_pix[2] = s1_pix_r;

    col_ctr[0] = dat_b[ENTRY_W-1:DATA_W];
    col_ctr[1] = dat_b[DATA_W-1:0];
    col_ctr[2] = '0;

    col_rgt[0] = s1_rok_r ? dat_a[ENTRY_W-1:DATA_W] : '0;
    col_rgt[1] = s1_rok_r ? dat_a[DATA_W-1:0] : '0;
    col_rgt[2] = '0;

    col_lft = s1_dzero_r ? '0 : win1_r;

    if (s1_drain_r) begin
      sel_l    = col_lft;
      sel_c    = col_ctr;
      sel_r    = col_rgt;
      win0_nxt = col_lft;
      win1_nxt = col_ctr;
    end else begin
      sel_l    = win0_r;
      sel_c    = win1_r;
      sel_r    = s1_ph_r ? '0 : col_pix;
      // first column of a row starts from a cleared window
      win0_nxt = s1_czero_r ? '0 : win1_r;
      win1_nxt = col_pix;
    end

    for (int ky = 0; ky < c3sr_pkg::TAPS; ky++) begin
      job_nxt.px[ky][0] = sel_l[ky];
      job_nxt.px[ky][1] = sel_c[ky];
      job_nxt.px[ky][2] = sel_r[ky];
    end
    job_nxt.run_end   = s1_drain_r || s1_ph_r || !s1_emit_b_r;
    job_nxt.plane_end = s1_drain_r && s1_plast_r;
  end

  always_comb begin
    credit_ok = count_r < CNT_W'(c3sr_pkg::FIFO_DEPTH);
    need_job  = s1_valid_r && (s1_drain_r || s1_ph_r || s1_emit_a_r);
    job_go    = need_job && credit_ok;
    step_ok   = s1_valid_r && (!need_job || credit_ok);
    s1_exit   = step_ok && !(!s1_drain_r && !s1_ph_r && s1_emit_b_r);
    s1_wr     = s1_exit && !s1_drain_r;
  end

  always_ff @(posedge clk) begin
    if (step_ok && !s1_ph_r) begin
      win0_r <= win0_nxt;
      win1_r <= win1_nxt;
    end
  end

  // ---------------------------------------------------------------- MAC + queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      job_valid_r <= job_go;
      count_r     <= count_r + CNT_W'(job_go) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (job_go) begin
      job_r <= job_nxt;
    end
  end

  c3sr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid_r),
    .job       (job_r),
    .kernel    (kernel_r),
    .bias      (bias_r),
    .res_valid (res_valid),
    .res       (res)
  );

  c3sr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .din       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (fifo_dout)
  );

  assign pop           = out_valid && out_ready;
  assign out_feature   = fifo_dout.feature;
  assign out_run_end   = fifo_dout.run_end;
  assign out_plane_end = fifo_dout.plane_end;

  // ---------------------------------------------------------------- checks
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(c3sr_pkg::FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_r != '0)
    else $error("result queued without an outstanding credit");

  a_second_phase: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ph_r |-> (s1_valid_r && !s1_drain_r && s1_emit_b_r))
    else $error("second result phase without a row-end pixel");

  a_plane_done: assert property (@(posedge clk) disable iff (!rst_n)
    (job_go && job_nxt.plane_end) |->
      (row_count_r == '0 && col_count_r == '0 && drain_count_r == '0))
    else $error("last drain result issued with counters not cleared");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (row_count_r <= side) && (SIZE_W'(col_count_r) < side))
    else $error("position counter outside the plane");

endmodule

// ===== bench/conv3x3_same_relu_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_same_relu_tb
// Self-checking bench: streams pixel planes through the 3x3 same-padding
// conv + ReLU, predicts every feature in a local line-store/window model and
// checks each output transfer in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module conv3x3_same_relu_tb;

  localparam int DATA_W     = c3sr_pkg::DATA_W;
  localparam int TAPS       = c3sr_pkg::TAPS;
  localparam int WGT_W      = c3sr_pkg::WGT_W;
  localparam int KROW_W     = c3sr_pkg::KROW_W;
  localparam int PS_W       = c3sr_pkg::PS_W;
  localparam int ENTRY_W    = c3sr_pkg::ENTRY_W;
  localparam int MAX_SIZE   = c3sr_pkg::MAX_SIZE;
  localparam int FRAC_BITS  = c3sr_pkg::FRAC_BITS;
  localparam int CFG_IDX_W  = c3sr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = c3sr_pkg::CFG_DATA_W;

  localparam int ACC_W         = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int STREAM_ITEMS  = 500;
  localparam int TAIL_PIXELS   = 32;
  localparam int SQUEEZE_LEN   = 300;

  typedef enum logic [1:0] {STEP_REG, STEP_ITEM, STEP_ITEM_KNOWN} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  op;
    logic [DATA_W-1:0]     pix;
    c3sr_pkg::res_t        want;
  } script_step_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = c3sr_pkg::OP_PIXEL;
  logic [DATA_W-1:0]     in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_W-1:0]     out_feature;
  logic                  out_run_end;
  logic                  out_plane_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // mirror of the block's registers and stream position
  logic [KROW_W-1:0]  krow [TAPS];
  logic [DATA_W-1:0]  bias_reg;
  logic [PS_W-1:0]    psize;
  logic [ENTRY_W-1:0] line_buf [MAX_SIZE];
  c3sr_pkg::col_t     win_l, win_m;
  int                 row_idx, col_idx, drain_idx;

  c3sr_pkg::res_t expected_features [$];
  script_step_t   script [$];

  int errors       = 0;
  int stream_items = 0;
  int cycles       = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_stall     = 0;
  bit squeeze_on   = 1'b0;
  bit squeeze_done = 1'b0;

  conv3x3_same_relu DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_feature   (out_feature),
    .out_run_end   (out_run_end),
    .out_plane_end (out_plane_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d features still pending", $realtime,
               expected_features.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // bias + nine floored products, wrapped to the data width, then ReLU
  function automatic logic [DATA_W-1:0] relu_conv(input c3sr_pkg::col_t l,
                                                  input c3sr_pkg::col_t m,
                                                  input c3sr_pkg::col_t r);
    c3sr_pkg::col_t           cols [TAPS];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  prod;
    logic signed [DATA_W-1:0] px, wgt;
    logic [DATA_W-1:0]        sum;
    cols[0] = l;
    cols[1] = m;
    cols[2] = r;
    acc = ACC_W'($signed(bias_reg));
    for (int ky = 0; ky < TAPS; ky++) begin
      for (int kx = 0; kx < TAPS; kx++) begin
        px   = cols[kx][ky];
        wgt  = krow[ky][kx*WGT_W +: WGT_W];
        prod = px * wgt;
        acc  = acc + (prod >>> FRAC_BITS);
      end
    end
    sum = acc[DATA_W-1:0];
    return sum[DATA_W-1] ? '0 : sum;
  endfunction

  task automatic predict_features(input logic op, input logic [DATA_W-1:0] pix,
                                  output c3sr_pkg::res_t [1:0] outs, output int n);
    int                 w, x;
    logic [ENTRY_W-1:0] old, v;
    c3sr_pkg::col_t     fresh;
    c3sr_pkg::col_t     dcol [TAPS];
    n    = 0;
    outs = '0;
    w = (psize == '0) ? 1 : ((int'(psize) > MAX_SIZE) ? MAX_SIZE : int'(psize));
    if (op == c3sr_pkg::OP_PIXEL) begin
      // pixels past the end of the plane are dropped until the drain is done
      if (row_idx < w && col_idx < w) begin
        old = (row_idx == 0) ? '0 : line_buf[col_idx];
        fresh = {pix, old[DATA_W-1:0], old[ENTRY_W-1:DATA_W]};
        line_buf[col_idx] = {fresh[1], fresh[2]};
        if (col_idx == 0) begin
          win_l = '0;
          win_m = '0;
        end
        if (row_idx >= 1 && col_idx >= 1) begin
          outs[n] = '{relu_conv(win_l, win_m, fresh), 1'b0, 1'b0};
          n++;
        end
        win_l = win_m;
        win_m = fresh;
        // row end also releases the right-edge output with zero padding
        if (row_idx >= 1 && col_idx == w - 1) begin
          outs[n] = '{relu_conv(win_l, win_m, '0), 1'b0, 1'b0};
          n++;
        end
        col_idx++;
        if (col_idx >= w) begin
          col_idx = 0;
          row_idx++;
        end
      end
    end else if (row_idx >= w && drain_idx < w) begin
      for (int k = 0; k < TAPS; k++) begin
        x = drain_idx + k - 1;
        v = (x >= 0 && x < w) ? line_buf[x] : '0;
        dcol[k] = {{DATA_W{1'b0}}, v[DATA_W-1:0], v[ENTRY_W-1:DATA_W]};
      end
      outs[n] = '{relu_conv(dcol[0], dcol[1], dcol[2]), 1'b0, drain_idx == w - 1};
      n++;
      drain_idx++;
      if (drain_idx >= w) begin
        row_idx   = 0;
        col_idx   = 0;
        drain_idx = 0;
      end
    end
    if (n > 0) outs[n-1].run_end = 1'b1;
  endtask

  task automatic send_item(input logic op, input logic [DATA_W-1:0] pix,
                           input bit known, input c3sr_pkg::res_t want);
    c3sr_pkg::res_t [1:0] got;
    int                   n;
    cfg_valid <= 1'b0;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_pixel  <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_features(op, pix, got, n);
    if (known) begin
      expected_features.push_back(want);
    end else begin
      for (int i = 0; i < n; i++) expected_features.push_back(got[i]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      c3sr_pkg::REG_KERNEL_TOP: krow[0] = data;
      c3sr_pkg::REG_KERNEL_MID: krow[1] = data;
      c3sr_pkg::REG_KERNEL_BOT: krow[2] = data;
      c3sr_pkg::REG_BIAS:       bias_reg = data[DATA_W-1:0];
      c3sr_pkg::REG_PLANE_SIZE: begin
        // size changes only take effect between planes
        if (row_idx == 0 && col_idx == 0 && drain_idx == 0) psize = data[PS_W-1:0];
      end
      default: ;
    endcase
  endtask

  // let every pending feature out, plus the pipeline depth for dropped items
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    logic [KROW_W-1:0] k;
    for (int kx = 0; kx < TAPS; kx++) begin
      k[kx*WGT_W +: WGT_W] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 768) - 384);
    end
    return k;
  endfunction

  // one well-formed plane with an occasional out-of-place opcode mixed in
  task automatic run_plane(input int side_len, input int noise_pct);
    for (int i = 0; i < side_len * side_len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(c3sr_pkg::OP_DRAIN, 16'($urandom), 1'b0, '0);
      send_item(c3sr_pkg::OP_PIXEL, rand_pixel(), 1'b0, '0);
    end
    for (int d = 0; d < side_len; d++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(c3sr_pkg::OP_PIXEL, rand_pixel(), 1'b0, '0);
      send_item(c3sr_pkg::OP_DRAIN, 16'($urandom), 1'b0, '0);
    end
  endtask

  function automatic script_step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
    return '{STEP_REG, idx, data, c3sr_pkg::OP_PIXEL, '0, '0};
  endfunction

  function automatic script_step_t item_step(input logic op, input logic [DATA_W-1:0] pix);
    return '{STEP_ITEM, '0, '0, op, pix, '0};
  endfunction

  // single-result item whose output is obvious by hand
  function automatic script_step_t known_step(input logic op, input logic [DATA_W-1:0] pix,
                                              input logic [DATA_W-1:0] feature,
                                              input logic pend);
    return '{STEP_ITEM_KNOWN, '0, '0, op, pix, '{feature, 1'b1, pend}};
  endfunction

  // output side: checks each transfer, and stalls in bursts
  always @(posedge clk) begin : result_side
    c3sr_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_features.size() == 0) begin
        errors++;
        $display("%0t: feature expected none actual %h run_end %b plane_end %b",
                 $realtime, out_feature, out_run_end, out_plane_end);
      end else begin
        want = expected_features.pop_front();
        if (out_feature !== want.feature) begin
          errors++;
          $display("%0t: feature expected %h actual %h", $realtime, want.feature,
                   out_feature);
        end
        if (out_run_end !== want.run_end) begin
          errors++;
          $display("%0t: run_end expected %b actual %b", $realtime, want.run_end,
                   out_run_end);
        end
        if (out_plane_end !== want.plane_end) begin
          errors++;
          $display("%0t: plane_end expected %b actual %b", $realtime, want.plane_end,
                   out_plane_end);
        end
      end
    end
    if (rx_stall != 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (squeeze_on && !squeeze_done) begin
      // long hold-off: the result queue fills and the input must back up
      squeeze_done <= 1'b1;
      rx_stall     <= SQUEEZE_LEN - 1;
      out_ready    <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_stall  <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int ps, sz, pick;
    bit first_plane;
    foreach (line_buf[i]) line_buf[i] = '0;
    foreach (krow[i]) krow[i] = '0;
    bias_reg    = '0;
    psize       = PS_W'(1);
    win_l       = '0;
    win_m       = '0;
    row_idx     = 0;
    col_idx     = 0;
    drain_idx   = 0;
    first_plane = 1'b1;

    // one-pixel plane after reset, zero kernel; stray opcodes are dropped
    script.push_back(item_step(c3sr_pkg::OP_DRAIN, 16'h1234));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h7FFF));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h8000));
    script.push_back(known_step(c3sr_pkg::OP_DRAIN, 16'h0000, 16'h0000, 1'b1));
    // unit centre tap, size zero reads as one
    script.push_back(reg_step(c3sr_pkg::REG_KERNEL_MID, 48'h0000_0100_0000));
    script.push_back(reg_step(c3sr_pkg::REG_PLANE_SIZE, 48'h0));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h7FFF));
    script.push_back(known_step(c3sr_pkg::OP_DRAIN, 16'h0000, 16'h7FFF, 1'b1));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h8000));
    script.push_back(known_step(c3sr_pkg::OP_DRAIN, 16'hFFFF, 16'h0000, 1'b1));
    // 3x3 plane with extreme weights, bias and pixels
    script.push_back(reg_step(c3sr_pkg::REG_BIAS, 48'h7FFF));
    script.push_back(reg_step(c3sr_pkg::REG_KERNEL_TOP, 48'hFFFF_FFFF_FFFF));
    script.push_back(reg_step(c3sr_pkg::REG_KERNEL_BOT, 48'h8000_8000_8000));
    script.push_back(reg_step(c3sr_pkg::REG_PLANE_SIZE, 48'h3));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h7FFF));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h8000));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h0000));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h0001));
    // mid-plane writes: size is ignored, kernel and bias apply from here on
    script.push_back(reg_step(c3sr_pkg::REG_PLANE_SIZE, 48'h5));
    script.push_back(reg_step(c3sr_pkg::REG_BIAS, 48'h8000));
    script.push_back(reg_step(c3sr_pkg::REG_KERNEL_MID, 48'h7FFF_0100_8000));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'hFFFF));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h7FFF));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h8000));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'h00FF));
    script.push_back(item_step(c3sr_pkg::OP_PIXEL, 16'hFF00));
    script.push_back(item_step(c3sr_pkg::OP_DRAIN, 16'h0000));
    script.push_back(item_step(c3sr_pkg::OP_DRAIN, 16'hFFFF));
    script.push_back(item_step(c3sr_pkg::OP_DRAIN, 16'h5A5A));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        if (i == 0 || script[i-1].kind != STEP_REG) settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].op, script[i].pix, script[i].kind == STEP_ITEM_KNOWN,
                  script[i].want);
      end
    end

    while (stream_items < STREAM_ITEMS) begin
      settle();
      if ($urandom_range(0, 1) == 1) write_reg(c3sr_pkg::REG_KERNEL_TOP, rand_krow());
      if ($urandom_range(0, 1) == 1) write_reg(c3sr_pkg::REG_KERNEL_MID, rand_krow());
      if ($urandom_range(0, 1) == 1) write_reg(c3sr_pkg::REG_KERNEL_BOT, rand_krow());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(c3sr_pkg::REG_BIAS,
                  ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom_range(0, 65535))
                                              : CFG_DATA_W'(16'($urandom_range(0, 1024) - 512)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 5)       ps = 0;
      else if (pick < 75) ps = $urandom_range(1, 6);
      else if (pick < 95) ps = $urandom_range(7, 12);
      else                ps = $urandom_range(13, 20);
      // first plane is big enough to fill the block during the long hold-off
      if (first_plane) ps = 10;
      if (stream_items >= STREAM_ITEMS - 150 && ps > 6) ps = 6;
      write_reg(c3sr_pkg::REG_PLANE_SIZE, CFG_DATA_W'(ps));
      sz = (ps == 0) ? 1 : ps;
      if (stream_items >= STREAM_ITEMS - 150) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        pick = $urandom_range(0, 2);
        tx_idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
        pick = $urandom_range(0, 2);
        rx_idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
      end
      if (first_plane) squeeze_on = 1'b1;
      first_plane = 1'b0;
      run_plane(sz, 4);
      stream_items += sz * sz + sz;
    end

    // size register above the maximum: two full rows and part of a third
    settle();
    write_reg(c3sr_pkg::REG_KERNEL_TOP, rand_krow());
    write_reg(c3sr_pkg::REG_KERNEL_MID, rand_krow());
    write_reg(c3sr_pkg::REG_KERNEL_BOT, rand_krow());
    write_reg(c3sr_pkg::REG_BIAS, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(c3sr_pkg::REG_PLANE_SIZE, 48'hFF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 2 * MAX_SIZE + TAIL_PIXELS; i++) begin
      send_item(c3sr_pkg::OP_PIXEL, rand_pixel(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== conv3x3_same_relu.f =====
hw/rtl/c3sr_pkg.sv
hw/rtl/c3sr_mac.sv
hw/rtl/c3sr_fifo.sv
hw/rtl/conv3x3_same_relu.sv
bench/conv3x3_same_relu_tb.sv
